@@ rtl/mvc_pkg.sv @@
// Package for the multi-voice chorus: constants, request types, states and constant tables.
package mvc_pkg;

    localparam int LINE_DEPTH       = 4096;
    localparam int LINE_AW          = $clog2(LINE_DEPTH);
    localparam int MAX_VOICE_COUNT  = 8;
    localparam int VI_W             = (MAX_VOICE_COUNT > 1) ? $clog2(MAX_VOICE_COUNT) : 1;
    localparam int VC_W             = $clog2(MAX_VOICE_COUNT + 1);
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);

    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 17;
    localparam int SINE_W     = 17;
    localparam int MIX_W      = 17;
    localparam int STEP_W     = 24;
    localparam int DEPTH_W    = 18;
    localparam int BASE_W     = 19;
    localparam int DLY_W      = 20;
    localparam int PV_W       = STEP_W + VI_W;
    localparam int WET_W      = 41 + VI_W;
    localparam int LO_W       = 22;
    localparam int MIXLO_W    = LO_W + MIX_W;
    localparam int MIXHI_W    = WET_W - LO_W + MIX_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam longint unsigned DLY_MAX  = longint'(LINE_DEPTH - 1) * 256 - 1;
    localparam longint unsigned MIX_UNITY = 65536;
    localparam longint unsigned RECIP10   = 64'd3435973837;
    localparam int              RECIP_SH  = 35;

    localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_DELAY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 3'd5;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned SIN_C1  = 64'd1686629713;
    localparam longint unsigned SIN_C3  = 64'd693598668;
    localparam longint unsigned SIN_C5  = 64'd85569278;
    localparam longint unsigned SIN_C7  = 64'd5026990;
    localparam longint unsigned SIN_C9  = 64'd172266;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
    } t_out_req;

    typedef struct packed {
        logic                       we;
        logic [LINE_AW-1:0]         waddr;
        logic signed [SAMPLE_W-1:0] wdata;
        logic [LINE_AW-1:0]         raddr;
    } t_line_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_PHASE,
        ST_DELAY,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_ACC,
        ST_MIXL,
        ST_MIXR,
        ST_SUM
    } t_state;

    typedef logic [SINE_TABLE_DEPTH-1:0][SINE_W-1:0]          t_sine_rom;
    typedef logic [MAX_VOICE_COUNT:0][MAX_VOICE_COUNT-1:0][GAIN_W-1:0] t_gain_rom;
    typedef logic [MAX_VOICE_COUNT:0][MAX_VOICE_COUNT-1:0][31:0]       t_offs_rom;

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom         rom;
        longint unsigned   u;
        longint unsigned   q;
        longint unsigned   r;
        longint unsigned   t;
        longint unsigned   t2;
        longint unsigned   p;
        longint unsigned   lvl;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            u = ((longint'(i) << 32) / SINE_TABLE_DEPTH) & 64'hFFFF_FFFF;
            q = u >> 30;
            r = u & 64'h3FFF_FFFF;
            t = q[0] ? ONE_Q30 - r : r;
            t2 = (t * t) >> 30;
            p = SIN_C9;
            p = SIN_C7 - ((t2 * p) >> 30);
            p = SIN_C5 - ((t2 * p) >> 30);
            p = SIN_C3 - ((t2 * p) >> 30);
            p = SIN_C1 - ((t2 * p) >> 30);
            p = (t * p) >> 30;
            if (p > ONE_Q30) begin
                p = ONE_Q30;
            end
            lvl = (q < 2) ? ONE_Q30 + p : ONE_Q30 - p;
            rom[i] = SINE_W'((lvl + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    // Largest r with r * r * m <= x, which is the integer square root of floor(x / m).
    function automatic longint unsigned isqrt_scaled(input longint unsigned x,
                                                     input longint unsigned m);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        for (int k = 16; k >= 0; k--) begin
            b = 64'd1 << k;
            if ((r + b) * (r + b) * m <= x) begin
                r = r + b;
            end
        end
        return r;
    endfunction

    function automatic t_gain_rom build_gain_rom(input logic right);
        t_gain_rom       rom;
        longint unsigned m;
        longint unsigned num;
        rom = '0;
        for (int n = 1; n <= MAX_VOICE_COUNT; n++) begin
            m = (n > 1) ? longint'(n - 1) : 64'd1;
            for (int v = 0; v < n; v++) begin
                num = right ? longint'(v) : m - longint'(v);
                rom[n][v] = GAIN_W'(isqrt_scaled(num << 32, m));
            end
        end
        return rom;
    endfunction

    function automatic t_offs_rom build_offs_rom();
        t_offs_rom       rom;
        longint unsigned q;
        longint unsigned b;
        rom = '0;
        for (int n = 1; n <= MAX_VOICE_COUNT; n++) begin
            for (int v = 0; v < n; v++) begin
                q = 0;
                for (int k = 32; k >= 0; k--) begin
                    b = 64'd1 << k;
                    if ((q + b) * longint'(n) <= (longint'(v) << 32)) begin
                        q = q + b;
                    end
                end
                rom[n][v] = 32'(q);
            end
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM   = build_sine_rom();
    localparam t_gain_rom GAIN_L_ROM = build_gain_rom(1'b0);
    localparam t_gain_rom GAIN_R_ROM = build_gain_rom(1'b1);
    localparam t_offs_rom OFFS_ROM   = build_offs_rom();

endpackage

@@ rtl/mvc_line_ram.sv @@
// Delay-line memory with one write port and one registered read port.
module mvc_line_ram (
    input  logic                                i_clk,
    input  mvc_pkg::t_line_req                  i_req,
    output logic signed [mvc_pkg::SAMPLE_W-1:0] o_rd_data
);
    import mvc_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rd_data <= r_mem[i_req.raddr];
    end

endmodule

@@ rtl/multi_voice_chorus_unit.sv @@
// Top level of the multi-voice chorus: sequencer, per-voice datapath and output stage.
//
//  Channel   Direction  Signals                              Payload
//  input     in         i_in_valid / o_in_ready              i_in  (t_in_req)
//  output    out        o_out_valid / i_out_ready            o_out (t_out_req)
//  config    in         i_cfg_we, i_cfg_idx                  i_cfg_data
//
// The sequencer takes one request at a time, and a new one only once it is back in idle;
// each voice needs two reads of the single delay-line port plus interpolation and panning.
// After reset a clearing pass writes zero to all 4096 delay-line entries, during which
// o_in_ready stays low; configuration writes are taken throughout.
// The result waits in an output register, so a new request is accepted while it is pending;
// the sequencer only stalls at its last step if the previous result has not been taken.
module multi_voice_chorus_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mvc_pkg::t_in_req                  i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mvc_pkg::t_out_req                 o_out,
    input  logic                              i_cfg_we,
    input  logic [mvc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mvc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mvc_pkg::*;

    logic [3:0]          r_voice_count;
    logic [STEP_W-1:0]   r_phase_step;
    logic [DEPTH_W-1:0]  r_depth_delay;
    logic [BASE_W-1:0]   r_base_delay;
    logic [MIX_W-1:0]    r_mix_gain;
    logic                r_stereo_mode;

    t_state              r_state;
    t_state              n_state;
    logic [LINE_AW-1:0]  r_clr;
    logic [LINE_AW-1:0]  r_wp;
    logic [VI_W-1:0]     r_v;
    logic [VC_W-1:0]     r_voices;
    logic [31:0]         r_phase [MAX_VOICE_COUNT];
    t_in_req             r_in;
    logic                r_out_valid;
    t_out_req            r_out;

    logic [SINE_W-1:0]           r_sine;
    logic [PV_W-1:0]             r_pv;
    logic [31:0]                 r_q;
    logic [LINE_AW-1:0]          r_i0;
    logic [LINE_AW-1:0]          r_i1;
    logic [7:0]                  r_f;
    logic signed [SAMPLE_W-1:0]  r_x0;
    logic signed [SAMPLE_W-1:0]  r_w;
    logic signed [WET_W-1:0]     r_wet_l;
    logic signed [WET_W-1:0]     r_wet_r;
    logic [MIXLO_W-1:0]          r_pl_lo;
    logic signed [MIXHI_W-1:0]   r_pl_hi;
    logic [MIXLO_W-1:0]          r_pr_lo;
    logic signed [MIXHI_W-1:0]   r_pr_hi;
    logic signed [SAMPLE_W-1:0]  r_ol;

    t_line_req                   line_req;
    logic signed [SAMPLE_W-1:0]  rd_data;
    logic                        out_free;
    logic                        last_voice;
    logic [VC_W-1:0]             voices_clamped;
    logic [MIX_W-1:0]            mix;
    logic signed [SAMPLE_W:0]    mono_sum;
    logic [31:0]                 ph;
    logic [DEPTH_W+SINE_W-1:0]   depth_prod;
    logic [DLY_W-1:0]            dly;
    logic [DLY_W-1:0]            dly_sat;
    logic [LINE_AW-1:0]          di;
    logic [8:0]                  f_inv;
    logic signed [33:0]          interp;
    logic signed [WET_W-1:0]     tap_l;
    logic signed [WET_W-1:0]     tap_r;

    function automatic logic signed [SAMPLE_W-1:0] mix_out(
        input logic signed [SAMPLE_W-1:0] dry,
        input logic [MIXLO_W-1:0]         lo,
        input logic signed [MIXHI_W-1:0]  hi
    );
        logic signed [62:0] tot;
        logic signed [31:0] s;
        tot = (63'(hi) <<< LO_W) + $signed({1'b0, 62'(lo)});
        s = 32'(dry) + 32'(tot >>> 32);
        if (s > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (s < -32'sd8388608) begin
            return 24'sh800000;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    mvc_line_ram u_line (
        .i_clk     (i_clk),
        .i_req     (line_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_count <= 4'd3;
            r_phase_step  <= STEP_W'(53687);
            r_depth_delay <= DEPTH_W'(49152);
            r_base_delay  <= BASE_W'(221184);
            r_mix_gain    <= MIX_W'(32768);
            r_stereo_mode <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VOICE_COUNT: r_voice_count <= i_cfg_data[3:0];
                REG_PHASE_STEP:  r_phase_step  <= i_cfg_data[STEP_W-1:0];
                REG_DEPTH_DELAY: r_depth_delay <= i_cfg_data[DEPTH_W-1:0];
                REG_BASE_DELAY:  r_base_delay  <= i_cfg_data[BASE_W-1:0];
                REG_MIX_GAIN:    r_mix_gain    <= i_cfg_data[MIX_W-1:0];
                REG_STEREO_MODE: r_stereo_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign last_voice = (r_v == VI_W'(r_voices - VC_W'(1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (&r_clr) n_state = ST_IDLE;
            ST_IDLE:   if (i_in_valid) n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_PHASE;
            ST_PHASE:  n_state = ST_DELAY;
            ST_DELAY:  n_state = ST_RD0;
            ST_RD0:    n_state = ST_RD1;
            ST_RD1:    n_state = ST_INTERP;
            ST_INTERP: n_state = ST_ACC;
            ST_ACC:    n_state = last_voice ? ST_MIXL : ST_PHASE;
            ST_MIXL:   n_state = ST_MIXR;
            ST_MIXR:   n_state = ST_SUM;
            ST_SUM:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    assign mono_sum = (SAMPLE_W+1)'(r_in.in_left) + (SAMPLE_W+1)'(r_in.in_right);

    always_comb begin
        o_in_ready     = 1'b0;
        line_req.we    = 1'b0;
        line_req.waddr = r_wp;
        line_req.wdata = mono_sum[SAMPLE_W:1];
        line_req.raddr = r_i0;
        unique case (r_state)
            ST_CLEAR: begin
                line_req.we    = 1'b1;
                line_req.waddr = r_clr;
                line_req.wdata = '0;
            end
            ST_IDLE:  o_in_ready = 1'b1;
            ST_WRITE: line_req.we = 1'b1;
            ST_RD1:   line_req.raddr = r_i1;
            default: ;
        endcase
    end

    always_comb begin
        if (r_voice_count == 4'd0) begin
            voices_clamped = VC_W'(1);
        end else if (32'(r_voice_count) > MAX_VOICE_COUNT) begin
            voices_clamped = VC_W'(MAX_VOICE_COUNT);
        end else begin
            voices_clamped = VC_W'(r_voice_count);
        end
        mix = (32'(r_mix_gain) > MIX_UNITY) ? MIX_W'(MIX_UNITY) : r_mix_gain;
    end

    always_comb begin
        ph         = r_phase[r_v] + OFFS_ROM[r_voices][r_v];
        depth_prod = (DEPTH_W+SINE_W)'(r_depth_delay) * (DEPTH_W+SINE_W)'(r_sine);
        dly        = DLY_W'(r_base_delay) + DLY_W'(depth_prod >> 16);
        dly_sat    = (64'(dly) > DLY_MAX) ? DLY_W'(DLY_MAX) : dly;
        di         = LINE_AW'(dly_sat >> 8);
        f_inv      = 9'd256 - 9'(r_f);
        interp     = 34'(r_x0 * $signed({1'b0, f_inv}))
                   + 34'(rd_data * $signed({1'b0, r_f}));
        tap_l      = WET_W'(r_w * $signed({1'b0, GAIN_L_ROM[r_voices][r_v]}));
        tap_r      = WET_W'(r_w * $signed({1'b0, GAIN_R_ROM[r_voices][r_v]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_v         <= '0;
            r_voices    <= VC_W'(1);
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_VOICE_COUNT; k++) begin
                r_phase[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + LINE_AW'(1);
            end
            if (r_state == ST_IDLE && i_in_valid) begin
                r_voices <= voices_clamped;
            end
            if (r_state == ST_WRITE) begin
                r_v <= '0;
            end
            if (r_state == ST_ACC) begin
                r_phase[r_v] <= r_phase[r_v] + 32'(r_phase_step) + r_q;
                r_v          <= r_v + VI_W'(1);
            end
            if (r_state == ST_SUM && out_free) begin
                r_out_valid <= 1'b1;
                r_wp        <= r_wp + LINE_AW'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_in.in_left  <= i_in.in_left;
            r_in.in_right <= r_stereo_mode ? i_in.in_right : i_in.in_left;
        end
        if (r_state == ST_WRITE) begin
            r_wet_l <= '0;
            r_wet_r <= '0;
        end
        if (r_state == ST_PHASE) begin
            r_sine <= SINE_ROM[ph[31 -: SINE_AW]];
            r_pv   <= PV_W'(r_phase_step) * PV_W'(r_v);
        end
        if (r_state == ST_DELAY) begin
            r_i0 <= r_wp - di;
            r_i1 <= r_wp - di - LINE_AW'(1);
            r_f  <= dly_sat[7:0];
            r_q  <= 32'((64'(r_pv) * RECIP10) >> RECIP_SH);
        end
        if (r_state == ST_RD1) begin
            r_x0 <= rd_data;
        end
        if (r_state == ST_INTERP) begin
            r_w <= interp[31:8];
        end
        if (r_state == ST_ACC) begin
            r_wet_l <= r_wet_l + tap_l;
            r_wet_r <= r_wet_r + tap_r;
        end
        if (r_state == ST_MIXL) begin
            r_pl_lo <= MIXLO_W'(mix) * MIXLO_W'(r_wet_l[LO_W-1:0]);
            r_pl_hi <= MIXHI_W'($signed({1'b0, mix}) * $signed(r_wet_l[WET_W-1:LO_W]));
        end
        if (r_state == ST_MIXR) begin
            r_pr_lo <= MIXLO_W'(mix) * MIXLO_W'(r_wet_r[LO_W-1:0]);
            r_pr_hi <= MIXHI_W'($signed({1'b0, mix}) * $signed(r_wet_r[WET_W-1:LO_W]));
            r_ol    <= mix_out(r_in.in_left, r_pl_lo, r_pl_hi);
        end
        if (r_state == ST_SUM && out_free) begin
            r_out.out_left  <= r_ol;
            r_out.out_right <= r_stereo_mode ? mix_out(r_in.in_right, r_pr_lo, r_pr_hi) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/mvc_checker.sv @@
// Port-level checker for the multi-voice chorus, bound to the top level.
module mvc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input mvc_pkg::t_out_req o_out
);
    import mvc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output request dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("Output payload changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("Second request accepted while one is still being processed.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("Block active immediately after reset.");

endmodule

bind multi_voice_chorus_unit mvc_checker u_mvc_checker (.*);

@@ test/multi_voice_chorus_unit_tb.sv @@
// Self-checking testbench for the multi-voice chorus with its own bit-exact predictor.
module multi_voice_chorus_unit_tb;
    import mvc_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_req            i_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_req           o_out;
    logic               i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_VOICE_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    multi_voice_chorus_unit uut (.*);

    always #1 i_clk = ~i_clk;

    t_in_req         pending_samples[$];
    t_out_req        expected_mix[$];
    int              errors = 0;
    bit              calm = 1'b0;
    int              send_gap = 0;
    int              recv_gap = 0;

    int unsigned     voices_reg = 3;
    int unsigned     step_reg = 53687;
    int unsigned     depth_reg = 49152;
    int unsigned     base_reg = 221184;
    int unsigned     mix_reg = 32768;
    bit              stereo_reg = 1'b1;
    logic signed [23:0] echo_line[LINE_DEPTH];
    int unsigned     line_ptr = 0;
    logic [31:0]     lfo_angle[MAX_VOICE_COUNT];

    function automatic longint unsigned sine_level(int unsigned idx);
        longint unsigned u, q, r, t, t2, p, lvl;
        u = longint'(idx) << 22;
        q = u >> 30;
        r = u & 64'h3FFF_FFFF;
        t = q[0] ? ONE_Q30 - r : r;
        t2 = (t * t) >> 30;
        p = SIN_C9;
        p = SIN_C7 - ((t2 * p) >> 30);
        p = SIN_C5 - ((t2 * p) >> 30);
        p = SIN_C3 - ((t2 * p) >> 30);
        p = SIN_C1 - ((t2 * p) >> 30);
        p = (t * p) >> 30;
        if (p > ONE_Q30) p = ONE_Q30;
        lvl = (q < 2) ? ONE_Q30 + p : ONE_Q30 - p;
        return (lvl + 64'd16384) >> 15;
    endfunction

    function automatic longint root_of(longint unsigned x);
        longint unsigned r;
        r = 0;
        for (int k = 16; k >= 0; k--) begin
            if ((r + (64'd1 << k)) * (r + (64'd1 << k)) <= x) r = r + (64'd1 << k);
        end
        return longint'(r);
    endfunction

    function automatic longint clip24(longint x);
        if (x > 8388607) return 8388607;
        if (x < -8388608) return -8388608;
        return x;
    endfunction

    function automatic t_out_req chorus_sample(t_in_req s);
        t_out_req res;
        longint l, r, wl, wr, w, gl, gr, mix;
        longint unsigned d, dmax, m, nv;
        int unsigned di, f, i0, i1, offs;
        logic [31:0] ph;
        l = s.in_left;
        r = stereo_reg ? longint'(s.in_right) : l;
        nv = voices_reg < 1 ? 1 : (voices_reg > MAX_VOICE_COUNT ? MAX_VOICE_COUNT : voices_reg);
        m = nv > 1 ? nv - 1 : 1;
        mix = mix_reg > 65536 ? 65536 : mix_reg;
        dmax = longint'(LINE_DEPTH - 1) * 256 - 1;
        wl = 0;
        wr = 0;
        echo_line[line_ptr] = 24'((l + r) >>> 1);
        for (int v = 0; v < nv; v++) begin
            offs = 32'((longint'(v) << 32) / nv);
            ph = lfo_angle[v] + offs;
            d = base_reg + ((longint'(depth_reg) * sine_level(ph >> 22)) >> 16);
            if (d > dmax) d = dmax;
            di = d >> 8;
            f = d & 255;
            i0 = (line_ptr + LINE_DEPTH - di) % LINE_DEPTH;
            i1 = (line_ptr + 2 * LINE_DEPTH - di - 1) % LINE_DEPTH;
            w = (longint'(echo_line[i0]) * longint'(256 - f)
                 + longint'(echo_line[i1]) * longint'(f)) >>> 8;
            gl = root_of(((m - v) << 32) / m);
            gr = root_of((longint'(v) << 32) / m);
            wl += gl * w;
            wr += gr * w;
            lfo_angle[v] = lfo_angle[v] + 32'((longint'(step_reg) * (10 + v)) / 10);
        end
        res.out_left = 24'(clip24(l + ((mix * wl) >>> 32)));
        res.out_right = stereo_reg ? 24'(clip24(r + ((mix * wr) >>> 32))) : '0;
        line_ptr = (line_ptr + 1) % LINE_DEPTH;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_in_req nxt;
        logic    vld;
        vld = i_in_valid;
        nxt = i_in;
        if (i_in_valid && o_in_ready) begin
            expected_mix.insert(expected_mix.size(), chorus_sample(i_in));
            vld = 1'b0;
        end
        if (!vld) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 8);
            end else if (pending_samples.size() > 0) begin
                nxt = pending_samples.pop_front();
                vld = 1'b1;
            end
        end
        i_in_valid <= vld;
        i_in <= nxt;
    end

    always @(posedge i_clk) begin
        t_out_req want;
        if (o_out_valid && i_out_ready) begin
            if (expected_mix.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out);
                errors++;
            end else begin
                want = expected_mix.pop_front();
                if (want.out_left !== o_out.out_left) begin
                    $display("%0t: out_left expected %0d actual %0d", $time,
                             want.out_left, o_out.out_left);
                    errors++;
                end
                if (want.out_right !== o_out.out_right) begin
                    $display("%0t: out_right expected %0d actual %0d", $time,
                             want.out_right, o_out.out_right);
                    errors++;
                end
            end
        end
        if (recv_gap > 0) begin
            recv_gap--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            REG_VOICE_COUNT: voices_reg = val & 32'hF;
            REG_PHASE_STEP:  step_reg = val & 32'hFF_FFFF;
            REG_DEPTH_DELAY: depth_reg = val & 32'h3_FFFF;
            REG_BASE_DELAY:  base_reg = val & 32'h7_FFFF;
            REG_MIX_GAIN:    mix_reg = val & 32'h1_FFFF;
            REG_STEREO_MODE: stereo_reg = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(int unsigned vc, int unsigned st, int unsigned dp, int unsigned bs,
                         int unsigned mx, int unsigned sm);
        write_reg(REG_VOICE_COUNT, vc);
        write_reg(REG_PHASE_STEP, st);
        write_reg(REG_DEPTH_DELAY, dp);
        write_reg(REG_BASE_DELAY, bs);
        write_reg(REG_MIX_GAIN, mx);
        write_reg(REG_STEREO_MODE, sm);
        write_reg(3'(REG_STEREO_MODE + 1), $urandom);
        write_reg(3'(REG_STEREO_MODE + 2), $urandom);
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !i_in_valid && expected_mix.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'($urandom_range(0, 15)) - 24'd8;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        t_in_req s;
        int unsigned amp, ang;
        amp = $urandom_range(0, 22);
        ang = $urandom;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                ang += 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
                s.in_left = 24'($signed(24'(ang >> 8)) >>> (23 - amp));
                s.in_right = 24'($signed(24'((ang + 32'h4000_0000) >> 8)) >>> (23 - amp));
            end else begin
                s.in_left = pick_sample();
                s.in_right = pick_sample();
            end
            pending_samples.insert(pending_samples.size(), s);
        end
    endtask

    initial begin
        logic signed [23:0] edges[6];
        t_in_req s;
        foreach (lfo_angle[v]) lfo_angle[v] = '0;
        foreach (echo_line[a]) echo_line[a] = '0;
        edges = '{24'sh7F_FFFF, -24'sh80_0000, 24'sd0, -24'sd1, 24'sd1, -24'sd3};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (edges[a]) begin
            foreach (edges[b]) begin
                if (b % 2 == a % 2) begin
                    s.in_left = edges[a];
                    s.in_right = edges[b];
                    pending_samples.insert(pending_samples.size(), s);
                end
            end
        end
        drain();

        setup(0, 24'hFF_FFFF, 0, 0, 131071, 0);
        queue_random(12);
        drain();
        setup(15, 24'hFF_FFFF, 262143, 524287, 65536, 1);
        queue_random(12);
        drain();
        setup(1, 0, 0, 256, 0, 1);
        queue_random(8);
        drain();
        setup(8, 1000, 262143, 256, 65536, 0);
        queue_random(8);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            setup($urandom_range(0, 15), $urandom_range(0, 24'hFF_FFFF) >> $urandom_range(0, 12),
                  $urandom_range(0, 262143) >> $urandom_range(0, 8),
                  $urandom_range(256, 524287) >> $urandom_range(0, 9),
                  $urandom_range(0, 131071), $urandom_range(0, 1));
            if (ph == 9) calm = 1'b1;
            queue_random(100);
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule
